>>> rtl/ptli_pkg.sv
// Package for the profile table linear interpolator.
// Request and response payload types and request function codes.
// No dependencies.
package ptli_pkg;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] position;
      logic [31:0]        point_value;
   } req_type;

   typedef struct packed {
      logic [31:0] interpolated_value;
      logic        found;
      logic        table_full;
   } rsp_type;

endpackage

>>> rtl/ptli_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Requires dividend[63:32] < divisor so the quotient fits in 32 bits.
// Uses ptli_pkg (no items needed beyond the import convention).
module ptli_divider import ptli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] div_ff;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        take;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = ~diff[32];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd31;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[63:32];
         quo_ff <= dividend[31:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[31:0] : trial[31:0];
         quo_ff <= {quo_ff[30:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/profile_table_linear_interpolator_unit.sv
// Top level of the profile table linear interpolator.
// Holds the point table in two synchronous memories; uses ptli_pkg and ptli_divider.
//
//   Request channel (req_valid / req_stall / req_data): clear the table, append
//   a point, or query a position. Response channel (rsp_valid / rsp_stall /
//   rsp_data) returns exactly one response per request, in order.
//   One request is worked at a time; req_stall is high while it is in progress.
//   Clear, append, an unused code and a query under two points go straight to
//   the response. A query scans for the first segment that brackets the
//   position; a zero-length segment returns its first end's value, any other
//   is weighted, summed and passed through a serial divide, and a query that no
//   segment brackets returns found low. The scan reads one entry per cycle.
//   A response sits in an output register, so the next request is taken
//   while it waits on rsp_stall; a finished response that cannot be loaded
//   holds the block until the output register frees up.
//   Reset empties the table (count zero) and drops any work in flight; memory
//   contents are not cleared, only entries below the count are ever used.
module profile_table_linear_interpolator_unit import ptli_pkg::*; #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DIFF, ST_MUL0, ST_MUL1, ST_ADD, ST_DIV, ST_RESP
   } state_type;

   // |a - b| of two signed 32-bit numbers, exact as unsigned 32-bit
   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic [32:0] d;
      logic [32:0] n;
      d = {a[31], a} - {b[31], b};
      n = -d;
      return d[32] ? n[31:0] : d[31:0];
   endfunction

   // point memories
   logic signed [31:0] pos_mem [TABLE_DEPTH];
   logic [31:0]        val_mem [TABLE_DEPTH];
   logic signed [31:0] pos_rd_ff;
   logic [31:0]        val_rd_ff;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      rd_cnt_ff;      // next entry to read
   logic               dat_valid_ff;   // pos_rd_ff/val_rd_ff hold a fresh entry
   logic               have_prev_ff;
   logic signed [31:0] q_ff;
   logic signed [31:0] prev_pos_ff;
   logic [31:0]        prev_val_ff;
   logic signed [31:0] seg_a_ff;
   logic signed [31:0] seg_b_ff;
   logic [31:0]        v0_ff;
   logic [31:0]        v1_ff;
   logic [31:0]        wa_ff;          // weight of first end  = |b - q|
   logic [31:0]        wb_ff;          // weight of second end = |a - q|
   logic [31:0]        d_ff;           // segment length
   logic [63:0]        p0_ff;
   logic [63:0]        p1_ff;
   logic [63:0]        num_ff;
   logic               div_start_ff;
   rsp_type            res_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_accept;
   logic               app_wr;
   logic               has_room;
   logic               bracket;
   logic               out_free;
   logic               div_done;
   logic [31:0]        div_quo;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign has_room   = (count_ff < CW'(TABLE_DEPTH));
   assign app_wr     = req_accept & (req_data.func == FUNC_APPEND) & has_room;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // segment (prev, current) brackets q, inclusive, ends in either order
   assign bracket = ((prev_pos_ff <= q_ff) && (pos_rd_ff >= q_ff)) ||
                    ((prev_pos_ff >= q_ff) && (pos_rd_ff <= q_ff));

   always_ff @(posedge clock) begin
      if (app_wr) begin
         pos_mem[count_ff[AW-1:0]] <= req_data.position;
         val_mem[count_ff[AW-1:0]] <= req_data.point_value;
      end
      pos_rd_ff <= pos_mem[rd_cnt_ff[AW-1:0]];
      val_rd_ff <= val_mem[rd_cnt_ff[AW-1:0]];
   end

   ptli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (num_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         dat_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  res_ff       <= '0;
                  rd_cnt_ff    <= '0;
                  dat_valid_ff <= 1'b0;
                  have_prev_ff <= 1'b0;
                  q_ff         <= req_data.position;
                  state_ff     <= ST_RESP;
                  case (req_data.func)
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                     end
                     FUNC_APPEND: begin
                        if (has_room) begin
                           count_ff <= count_ff + CW'(1);
                        end else begin
                           res_ff.table_full <= 1'b1;
                        end
                     end
                     FUNC_QUERY: begin
                        if (count_ff >= CW'(2)) begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               dat_valid_ff <= (rd_cnt_ff < count_ff);
               if (rd_cnt_ff < count_ff) begin
                  rd_cnt_ff <= rd_cnt_ff + CW'(1);
               end
               if (dat_valid_ff) begin
                  if (have_prev_ff && bracket) begin
                     seg_a_ff <= prev_pos_ff;
                     seg_b_ff <= pos_rd_ff;
                     v0_ff    <= prev_val_ff;
                     v1_ff    <= val_rd_ff;
                     state_ff <= ST_DIFF;
                  end else begin
                     prev_pos_ff  <= pos_rd_ff;
                     prev_val_ff  <= val_rd_ff;
                     have_prev_ff <= 1'b1;
                     // last entry checked, nothing brackets q
                     if (rd_cnt_ff == count_ff) begin
                        state_ff <= ST_RESP;
                     end
                  end
               end
            end
            ST_DIFF: begin
               wa_ff    <= abs_diff(seg_b_ff, q_ff);
               wb_ff    <= abs_diff(seg_a_ff, q_ff);
               d_ff     <= abs_diff(seg_b_ff, seg_a_ff);
               state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               if (d_ff == 32'd0) begin
                  // both ends at the query: first end's value
                  res_ff.interpolated_value <= v0_ff;
                  res_ff.found              <= 1'b1;
                  state_ff                  <= ST_RESP;
               end else begin
                  p0_ff    <= 64'(v0_ff) * 64'(wa_ff);
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               p1_ff    <= 64'(v1_ff) * 64'(wb_ff);
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               num_ff       <= p0_ff + p1_ff;
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  res_ff.interpolated_value <= div_quo;
                  res_ff.found              <= 1'b1;
                  state_ff                  <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
